// ----- rtl/rsha_pkg.sv -----
// ----------------------------------------------------------------------------
// rsha_pkg
// Types, constants and the round function of the reduced SHA-256 compression.
// ----------------------------------------------------------------------------
package rsha_pkg;

	typedef logic [31:0] word_t;

	// Eight working or chaining words, index 0 is variable a.
	typedef word_t [0:7] state_t;

	localparam word_t ROUND_K = 32'h428a2f98;

	localparam state_t INIT_HASH = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// One classified input word as it travels from the front to the back.
	typedef struct packed {
		word_t word;
		logic  first;
		logic  restart;
		logic  last;
	} item_t;

	// Updated chaining value handed to the output stage.
	typedef struct packed {
		logic   valid;
		state_t words;
	} digest_load_t;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic state_t sha_round(input state_t wv, input word_t w);
		word_t sig0;
		word_t sig1;
		word_t ch;
		word_t maj;
		word_t t1;
		word_t t2;
		state_t r;
		sig1 = rotr(wv[4], 6) ^ rotr(wv[4], 11) ^ rotr(wv[4], 25);
		ch   = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
		t1   = wv[7] + sig1 + ch + ROUND_K + w;
		sig0 = rotr(wv[0], 2) ^ rotr(wv[0], 13) ^ rotr(wv[0], 22);
		maj  = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
		t2   = sig0 + maj;
		r[7] = wv[6];
		r[6] = wv[5];
		r[5] = wv[4];
		r[4] = wv[3] + t1;
		r[3] = wv[2];
		r[2] = wv[1];
		r[1] = wv[0];
		r[0] = t1 + t2;
		sha_round = r;
	endfunction

endpackage

// ----- rtl/rsha_front.sv -----
// ----------------------------------------------------------------------------
// rsha_front
// Accepts message words, tags each with its place in the block and holds
// them in a short queue for the round engine.
// ----------------------------------------------------------------------------
module rsha_front #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  rsha_pkg::word_t     message_word,
	input  logic                restart,
	output logic                q_valid,
	output rsha_pkg::item_t     q_item,
	input  logic                q_take
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rsha_pkg::item_t     mem_q [DEPTH];
	logic [PW-1:0]       wr_ptr_q;
	logic [PW-1:0]       rd_ptr_q;
	logic [CW-1:0]       count_q;
	logic [3:0]          pos_q;
	logic                do_push;
	logic                do_pop;
	rsha_pkg::item_t     new_item;

	assign full    = (count_q == CW'(DEPTH));
	assign q_valid = (count_q != '0);
	assign q_item  = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = q_take && q_valid;

	always_comb begin
		new_item.word    = message_word;
		new_item.first   = (pos_q == 4'd0);
		new_item.restart = restart && (pos_q == 4'd0);
		new_item.last    = (pos_q == 4'd15);
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			pos_q    <= '0;
		end else begin
			if (do_push) begin
				pos_q    <= pos_q + 4'd1;
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (!do_push && do_pop) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ----- rtl/rsha_back.sv -----
// ----------------------------------------------------------------------------
// rsha_back
// Round engine: one compression round per word, then the chaining value
// update once the sixteenth word has gone through.
// ----------------------------------------------------------------------------
module rsha_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  rsha_pkg::item_t       q_item,
	output logic                  q_take,
	input  logic                  out_ready,
	output rsha_pkg::digest_load_t load
);

	rsha_pkg::state_t cv_q;
	rsha_pkg::state_t wv_q;
	logic             fin_q;
	rsha_pkg::state_t base;
	rsha_pkg::state_t cv_sum;

	// The block is finished in a state of its own (fin_q), during which no word is taken.
	assign q_take = q_valid && !fin_q;

	always_comb begin
		if (q_item.first) begin
			base = q_item.restart ? rsha_pkg::INIT_HASH : cv_q;
		end else begin
			base = wv_q;
		end
		for (int k = 0; k < 8; k++) begin
			cv_sum[k] = cv_q[k] + wv_q[k];
		end
		load.valid = fin_q && out_ready;
		load.words = cv_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q  <= rsha_pkg::INIT_HASH;
			wv_q  <= '0;
			fin_q <= 1'b0;
		end else begin
			if (q_take) begin
				wv_q <= rsha_pkg::sha_round(base, q_item.word);
				if (q_item.restart) begin
					cv_q <= rsha_pkg::INIT_HASH;
				end
				if (q_item.last) begin
					fin_q <= 1'b1;
				end
			end else if (fin_q && out_ready) begin
				cv_q  <= cv_sum;
				fin_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/rsha_out.sv -----
// ----------------------------------------------------------------------------
// rsha_out
// Holds one updated chaining value and hands it out a word at a time.
// ----------------------------------------------------------------------------
module rsha_out (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rsha_pkg::digest_load_t load,
	output logic                   out_ready,
	output logic                   empty,
	input  logic                   pop,
	output rsha_pkg::word_t        digest_word,
	output logic [2:0]             digest_index,
	output logic                   last_word
);

	rsha_pkg::state_t digest_q;
	logic [2:0]       idx_q;
	logic             busy_q;

	assign out_ready    = !busy_q;
	assign empty        = !busy_q;
	assign digest_word  = digest_q[idx_q];
	assign digest_index = idx_q;
	assign last_word    = (idx_q == 3'd7);

	always_ff @(posedge clk) begin
		if (load.valid) begin
			digest_q <= load.words;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			busy_q <= 1'b0;
		end else begin
			if (load.valid) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (pop && busy_q) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == 3'd7) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ----- rtl/reduced_sha256_block_compress.sv -----
// ----------------------------------------------------------------------------
// reduced_sha256_block_compress
// Sixteen-round SHA-256 style compression with a single round constant and
// no message schedule; emits the eight updated chaining words per block.
// ----------------------------------------------------------------------------
//   Channel   Handshake     Word contents
//   input     push / full   message_word, restart
//   result    empty / pop   digest_word, digest_index, last_word
//
// Each word runs one round in the cycle it leaves the input queue, so words
// flow at one per cycle except while a block is finished: after its sixteenth
// word the engine takes no word until the chaining value add is done.
// The eight digest words are read out from a holding register, one per pop;
// the chaining add waits while that register still holds an unread digest.
// Reset returns the chaining value to the SHA-256 initial hash at once.
module reduced_sha256_block_compress #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] message_word,
	input  logic        restart,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] digest_word,
	output logic [2:0]  digest_index,
	output logic        last_word
);

	logic                   q_valid;
	logic                   q_take;
	rsha_pkg::item_t        q_item;
	logic                   out_ready;
	rsha_pkg::digest_load_t load;

	rsha_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.message_word(message_word),
		.restart     (restart),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_take      (q_take)
	);

	rsha_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_take   (q_take),
		.out_ready(out_ready),
		.load     (load)
	);

	rsha_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.out_ready   (out_ready),
		.empty       (empty),
		.pop         (pop),
		.digest_word (digest_word),
		.digest_index(digest_index),
		.last_word   (last_word)
	);

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks the reduced SHA-256 compression block: message words go in through
// the push/full side and the eight chaining words of each block come back
// through the empty/pop side. Every accepted word is run through a local
// sixteen-round model of the compression, and each digest word popped is
// compared with the oldest one that the model has queued.
// ----------------------------------------------------------------------------
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_WORDS = 300;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 32;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct packed {
		rsha_pkg::word_t word;
		logic            restart;
	} stim_row_t;

	typedef struct packed {
		rsha_pkg::word_t word;
		logic [2:0]      idx;
		logic            last;
	} digest_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        push         = 1'b0;
	logic        full;
	logic [31:0] message_word = '0;
	logic        restart      = 1'b0;
	logic        empty;
	logic        pop          = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  digest_index;
	logic        last_word;

	// Model state, updated as each word is accepted.
	rsha_pkg::state_t chain_val = rsha_pkg::INIT_HASH;
	rsha_pkg::state_t work_var  = '0;
	logic [3:0]       block_pos = '0;
	digest_t          digest_q[$];

	int  fail_count    = 0;
	int  cycle_count   = 0;
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	bit  hold_pending  = 1'b0;

	// The first block starts from the reset chaining value and carries restart
	// flags on inner words, which must be ignored; the second block restarts.
	stim_row_t directed_rows [0:24] = '{
		'{32'h0000_0000, 1'b0}, '{32'hffff_ffff, 1'b1}, '{32'h8000_0000, 1'b0},
		'{32'h0000_0001, 1'b1}, '{32'haaaa_aaaa, 1'b0}, '{32'h5555_5555, 1'b0},
		'{32'hffff_ffff, 1'b0}, '{32'hffff_ffff, 1'b0}, '{32'h0000_0000, 1'b1},
		'{32'h7fff_ffff, 1'b0}, '{32'hffff_fffe, 1'b0}, '{32'h0123_4567, 1'b0},
		'{32'h89ab_cdef, 1'b0}, '{32'h0f0f_0f0f, 1'b0}, '{32'hf0f0_f0f0, 1'b1},
		'{32'hffff_ffff, 1'b1},
		'{32'h0000_0000, 1'b1}, '{32'hffff_ffff, 1'b0}, '{32'h0000_0000, 1'b1},
		'{32'h8000_0000, 1'b0}, '{32'h0000_0001, 1'b0}, '{32'hffff_ffff, 1'b1},
		'{32'h5555_5555, 1'b0}, '{32'haaaa_aaaa, 1'b0}, '{32'h0000_0000, 1'b0}
	};

	reduced_sha256_block_compress u_top (
		.clk,
		.arst_n,
		.push,
		.full,
		.message_word,
		.restart,
		.empty,
		.pop,
		.digest_word,
		.digest_index,
		.last_word
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic rsha_pkg::word_t rotate_right(input rsha_pkg::word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// One round per accepted word; the sixteenth word folds the working
	// variables into the chaining value and queues the eight digest words.
	function automatic void compress_word(input rsha_pkg::word_t msg, input logic rst_flag);
		rsha_pkg::word_t s1;
		rsha_pkg::word_t ch;
		rsha_pkg::word_t t1;
		rsha_pkg::word_t s0;
		rsha_pkg::word_t mj;
		rsha_pkg::word_t t2;
		digest_t         d;
		int              k;
		if (block_pos == 4'd0) begin
			if (rst_flag)
				chain_val = rsha_pkg::INIT_HASH;
			work_var = chain_val;
		end
		s1 = rotate_right(work_var[4], 6) ^ rotate_right(work_var[4], 11) ^
			rotate_right(work_var[4], 25);
		ch = (work_var[4] & work_var[5]) ^ (~work_var[4] & work_var[6]);
		t1 = work_var[7] + s1 + ch + rsha_pkg::ROUND_K + msg;
		s0 = rotate_right(work_var[0], 2) ^ rotate_right(work_var[0], 13) ^
			rotate_right(work_var[0], 22);
		mj = (work_var[0] & work_var[1]) ^ (work_var[0] & work_var[2]) ^
			(work_var[1] & work_var[2]);
		t2 = s0 + mj;
		for (k = 7; k > 0; k--)
			work_var[k] = work_var[k - 1];
		// After the shift, slot 4 holds the old d.
		work_var[4] = work_var[4] + t1;
		work_var[0] = t1 + t2;
		block_pos = block_pos + 4'd1;
		if (block_pos == 4'd0) begin
			for (k = 0; k < 8; k++) begin
				chain_val[k] = chain_val[k] + work_var[k];
				d.word = chain_val[k];
				d.idx  = 3'(k);
				d.last = (k == 7);
				digest_q.push_back(d);
			end
		end
	endfunction

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch: %s", msg);
	endfunction

	// Offers one word and returns once it has been taken, with push left high.
	task automatic send_word(input rsha_pkg::word_t msg, input logic rst_flag);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push         <= 1'b1;
		message_word <= msg;
		restart      <= rst_flag;
		@(posedge clk);
		while (full)
			@(posedge clk);
		compress_word(msg, rst_flag);
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin : drain_results
		digest_t want;
		int      hold_left;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (digest_q.size() == 0) begin
					note_failure($sformatf("unexpected digest word %h index %0d last %b",
						digest_word, digest_index, last_word));
				end else begin
					want = digest_q.pop_front();
					if (digest_word !== want.word || digest_index !== want.idx ||
							last_word !== want.last)
						note_failure($sformatf(
							"expected word %h index %0d last %b, got %h index %0d last %b",
							want.word, want.idx, want.last,
							digest_word, digest_index, last_word));
				end
			end
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left    = LONG_HOLD;
			end
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin : stimulus
		int              n;
		rsha_pkg::word_t w;
		logic            r;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 7;
		recv_idle_pct = 64;
		foreach (directed_rows[i])
			send_word(directed_rows[i].word, directed_rows[i].restart);

		for (n = 0; n < RANDOM_WORDS; n++) begin
			if (n == RANDOM_WORDS / 3) begin
				send_idle_pct = 64;
				recv_idle_pct = 7;
			end
			if (n == 2 * RANDOM_WORDS / 3) begin
				// The receiver stops for a long while so that the block backs up.
				send_idle_pct = 0;
				recv_idle_pct = 0;
				hold_pending  = 1'b1;
			end
			case ($urandom_range(9))
				0:       w = '0;
				1:       w = '1;
				2:       w = rsha_pkg::word_t'(1) << $urandom_range(31);
				default: w = $urandom;
			endcase
			if (block_pos == 4'd0)
				r = 1'($urandom_range(1));
			else
				r = ($urandom_range(3) == 0);
			send_word(w, r);
		end
		push <= 1'b0;

		while (digest_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && digest_q.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
